// ===== hdl/lgf_pkg.sv =====
package lgf_pkg;

   localparam int CoordWidth = 24;
   localparam int MaxGapDefault = 63;

   typedef enum logic [1:0] {
      KIND_MEASURED = 2'd0,
      KIND_INTERP   = 2'd1,
      KIND_HELD     = 2'd2,
      KIND_UNFILLED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_LAST
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture the accepted transfer
      logic clear_idx;   // restart the emit counter
      logic div_start;   // start the three divisions for the current index
      logic emit;        // load the output register
      logic step_idx;    // advance the emit counter
      logic last_sel;    // the current result is the closing one
      logic commit;      // update held state after the run
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;    // run is interpolated
      logic run_empty;   // only the closing result remains
      logic idx_last;    // counter sits on the final filled result
      logic div_done;
      logic buffer_only; // transfer is counted and gives no result
   } status_type;

endpackage

// ===== hdl/lgf_divider.sv =====
module lgf_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [56:0] numer,   // non-negative dividend
   input  logic [7:0]  denom,
   output logic [56:0] quot,
   output logic        rem_zero,
   output logic        done
);
   import lgf_pkg::*;

   logic [56:0] q_ff, q_in;
   logic [8:0]  r_ff, r_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [8:0]  trial;

   // restoring division, one quotient bit a cycle
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[7:0], q_ff[56]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         cnt_in = 6'd56;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, denom}) begin
            r_in = trial - {1'b0, denom};
            q_in = {q_ff[55:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[55:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = q_ff;
   assign rem_zero = (r_ff == '0);
   assign done = done_ff;

   property p_no_done_on_start;
      @(posedge clock) disable iff (reset) start |=> !done;
   endproperty
   a_no_done_on_start: assert property (p_no_done_on_start) else $error("done after start");

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) done |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

   property p_busy_count;
      @(posedge clock) disable iff (reset) (busy_ff && cnt_ff != 6'd0 && !start) |=> busy_ff;
   endproperty
   a_busy_count: assert property (p_busy_count) else $error("busy dropped early");

endmodule

// ===== hdl/lgf_datapath.sv =====
module lgf_datapath #(
   parameter int MAX_GAP = lgf_pkg::MaxGapDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lgf_pkg::cmd_type      cmd,
   output lgf_pkg::status_type   status,
   input  logic signed [23:0]    req_pos_x,
   input  logic signed [23:0]    req_pos_y,
   input  logic signed [23:0]    req_pos_z,
   input  logic                  req_hidden,
   input  logic                  req_final_frame,
   output logic signed [23:0]    rsp_out_x,
   output logic signed [23:0]    rsp_out_y,
   output logic signed [23:0]    rsp_out_z,
   output logic                  rsp_out_hidden,
   output logic [1:0]            rsp_fill_kind,
   output logic                  rsp_run_end,
   output logic                  rsp_sequence_end
);
   import lgf_pkg::*;

   logic signed [23:0] held_x_ff, held_y_ff, held_z_ff;
   logic               seen_ff, given_up_ff;
   logic [6:0]         pend_ff, pend_in;
   logic signed [23:0] nx_ff, ny_ff, nz_ff;
   logic               nhid_ff, nfin_ff;
   logic [6:0]         nfill_ff;     // filled results before the closing one
   kind_type           kind_ff;
   logic               interp_ff;
   logic               close_ff;     // closing result is the new visible frame
   logic signed [23:0] fx_ff, fy_ff, fz_ff;
   logic [6:0]         idx_ff;
   logic               give_up, do_buffer;
   logic [7:0]         den;

   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic [56:0]        numx, numy, numz, qx, qy, qz;
   logic               negx_ff, negy_ff, negz_ff;
   logic               dnx, dny, dnz;
   logic               rzx, rzy, rzz;
   logic signed [32:0] prod [3];
   logic signed [57:0] sprod [3];
   logic [57:0]        mag [3];
   logic signed [24:0] dsel [3];

   assign give_up = given_up_ff || (pend_ff >= 7'(MAX_GAP));
   assign do_buffer = req_hidden && !give_up && !req_final_frame;
   assign den = {1'b0, nfill_ff} + 8'd1;

   always_comb begin
      pend_in = pend_ff;
      if (do_buffer) pend_in = pend_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_z_ff <= '0;
         seen_ff <= 1'b0;
         given_up_ff <= 1'b0;
         pend_ff <= '0;
      end else if (cmd.load && do_buffer) begin
         pend_ff <= pend_in;
      end else if (cmd.commit) begin
         if (nfin_ff) begin
            held_x_ff <= '0;
            held_y_ff <= '0;
            held_z_ff <= '0;
            seen_ff <= 1'b0;
            given_up_ff <= 1'b0;
         end else if (!nhid_ff) begin
            held_x_ff <= nx_ff;
            held_y_ff <= ny_ff;
            held_z_ff <= nz_ff;
            seen_ff <= 1'b1;
            given_up_ff <= 1'b0;
         end else if (kind_ff == KIND_UNFILLED && given_up_ff | interp_ff) begin
            given_up_ff <= 1'b1;
         end
         pend_ff <= '0;
      end
   end

   // run description of the accepted transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nx_ff <= req_pos_x;
         ny_ff <= req_pos_y;
         nz_ff <= req_pos_z;
         nhid_ff <= req_hidden;
         nfin_ff <= req_final_frame;
         dx_ff <= 25'(req_pos_x) - 25'(held_x_ff);
         dy_ff <= 25'(req_pos_y) - 25'(held_y_ff);
         dz_ff <= 25'(req_pos_z) - 25'(held_z_ff);
         if (req_hidden) begin
            // flush: pending frames and this one, all held or unfilled
            nfill_ff <= pend_ff;
            close_ff <= 1'b0;
            interp_ff <= give_up;  // reused as give-up mark for the commit
            kind_ff <= (!give_up && seen_ff) ? KIND_HELD : KIND_UNFILLED;
            fx_ff <= seen_ff ? held_x_ff : '0;
            fy_ff <= seen_ff ? held_y_ff : '0;
            fz_ff <= seen_ff ? held_z_ff : '0;
         end else begin
            close_ff <= 1'b1;
            if (pend_ff != '0 && !given_up_ff) begin
               nfill_ff <= pend_ff;
               interp_ff <= seen_ff;
               kind_ff <= seen_ff ? KIND_INTERP : KIND_HELD;
            end else begin
               nfill_ff <= '0;
               interp_ff <= 1'b0;
               kind_ff <= KIND_MEASURED;
            end
            fx_ff <= req_pos_x;
            fy_ff <= req_pos_y;
            fz_ff <= req_pos_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_idx) idx_ff <= 7'd1;
      else if (cmd.step_idx) idx_ff <= idx_ff + 7'd1;
   end

   // 2*d*i + den made non-negative, sign kept aside; floor fixed after division
   assign dsel[0] = dx_ff;
   assign dsel[1] = dy_ff;
   assign dsel[2] = dz_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod[k] = 33'(dsel[k]) * 33'(signed'({1'b0, idx_ff}));
         sprod[k] = (58'(prod[k]) <<< 1) + 58'(den);
         mag[k] = sprod[k][57] ? 58'(-sprod[k]) : 58'(sprod[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         negx_ff <= sprod[0][57];
         negy_ff <= sprod[1][57];
         negz_ff <= sprod[2][57];
      end
   end

   // the divisor is 2*den, so halve the dividend instead and fold the lost bit
   // into the floor correction for negatives
   logic [56:0] magq [3];
   logic        magl [3];
   logic        magl_ff [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         magq[k] = mag[k][57:1];
         magl[k] = mag[k][0];
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         for (int k = 0; k < 3; k++) magl_ff[k] <= magl[k];
      end
   end

   assign numx = magq[0];
   assign numy = magq[1];
   assign numz = magq[2];

   lgf_divider u_divx (.clock, .reset, .start(cmd.div_start), .numer(numx), .denom(den),
                       .quot(qx), .rem_zero(rzx), .done(dnx));
   lgf_divider u_divy (.clock, .reset, .start(cmd.div_start), .numer(numy), .denom(den),
                       .quot(qy), .rem_zero(rzy), .done(dny));
   lgf_divider u_divz (.clock, .reset, .start(cmd.div_start), .numer(numz), .denom(den),
                       .quot(qz), .rem_zero(rzz), .done(dnz));

   // exact when the divider remainder and the dropped bit are both zero;
   // otherwise floor needs one more for negatives
   function automatic logic signed [24:0] fix_q(input logic [56:0] q, input logic neg,
                                                input logic lsb, input logic rz);
      logic exact;
      exact = rz && !lsb;
      if (!neg) fix_q = 25'(q);
      else if (exact) fix_q = -25'(q);
      else fix_q = -25'(q) - 25'sd1;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (cmd.last_sel) begin
            rsp_out_x <= close_ff ? nx_ff : fx_ff;
            rsp_out_y <= close_ff ? ny_ff : fy_ff;
            rsp_out_z <= close_ff ? nz_ff : fz_ff;
            rsp_out_hidden <= nhid_ff;
            rsp_fill_kind <= close_ff ? KIND_MEASURED : kind_ff;
            rsp_run_end <= 1'b1;
            rsp_sequence_end <= nfin_ff;
         end else begin
            if (interp_ff && close_ff) begin
               rsp_out_x <= 24'(25'(held_x_ff) + fix_q(qx, negx_ff, magl_ff[0], rzx));
               rsp_out_y <= 24'(25'(held_y_ff) + fix_q(qy, negy_ff, magl_ff[1], rzy));
               rsp_out_z <= 24'(25'(held_z_ff) + fix_q(qz, negz_ff, magl_ff[2], rzz));
            end else begin
               rsp_out_x <= fx_ff;
               rsp_out_y <= fy_ff;
               rsp_out_z <= fz_ff;
            end
            rsp_out_hidden <= 1'b1;
            rsp_fill_kind <= kind_ff;
            rsp_run_end <= 1'b0;
            rsp_sequence_end <= 1'b0;
         end
      end
   end

   assign status.need_div = interp_ff && close_ff;
   assign status.run_empty = (nfill_ff == '0);
   assign status.idx_last = (idx_ff >= nfill_ff);
   assign status.div_done = dnx;
   assign status.buffer_only = do_buffer;

   property p_pend_bound;
      @(posedge clock) disable iff (reset) pend_ff <= 7'(MAX_GAP);
   endproperty
   a_pend_bound: assert property (p_pend_bound) else $error("pending count overflow");

   property p_div_lockstep;
      @(posedge clock) disable iff (reset) (dnx == dny) && (dny == dnz);
   endproperty
   a_div_lockstep: assert property (p_div_lockstep) else $error("dividers out of step");

   property p_commit_clears;
      @(posedge clock) disable iff (reset) cmd.commit |=> pend_ff == '0;
   endproperty
   a_commit_clears: assert property (p_commit_clears) else $error("pending not cleared");

endmodule

// ===== hdl/lgf_control.sv =====
module lgf_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  lgf_pkg::status_type   status,
   output lgf_pkg::cmd_type      cmd
);
   import lgf_pkg::*;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;
   logic      free;
   logic      acc;

   // output register can take a new result when empty or being drained
   assign free = !rv_ff || !rsp_stall;
   assign acc = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.buffer_only) begin
               if (status.need_div) state_in = ST_DIV_START;
               else state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (status.run_empty) state_in = ST_LAST;
            else if (status.need_div) state_in = ST_DIV_WAIT;
            else state_in = ST_EMIT;
         end
         ST_DIV_WAIT: if (status.div_done) state_in = ST_EMIT;
         ST_EMIT: begin
            if (free) begin
               if (status.idx_last) state_in = ST_LAST;
               else if (status.need_div) state_in = ST_DIV_START;
            end
         end
         ST_LAST: if (free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      rv_in = rv_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = acc;
            cmd.clear_idx = 1'b1;
         end
         ST_DIV_START: cmd.div_start = status.need_div && !status.run_empty;
         ST_EMIT: begin
            if (free) begin
               cmd.emit = 1'b1;
               cmd.step_idx = 1'b1;
               rv_in = 1'b1;
            end
         end
         ST_LAST: begin
            if (free) begin
               cmd.emit = 1'b1;
               cmd.last_sel = 1'b1;
               cmd.commit = 1'b1;
               rv_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;

   property p_emit_when_free;
      @(posedge clock) disable iff (reset) cmd.emit |-> free;
   endproperty
   a_emit_when_free: assert property (p_emit_when_free) else $error("result overwritten");

   property p_commit_leaves;
      @(posedge clock) disable iff (reset) cmd.commit |=> state_ff == ST_IDLE;
   endproperty
   a_commit_leaves: assert property (p_commit_leaves) else $error("commit without return");

   property p_load_idle;
      @(posedge clock) disable iff (reset) cmd.load |-> !req_stall;
   endproperty
   a_load_idle: assert property (p_load_idle) else $error("load while busy");

endmodule

// ===== hdl/linear_gap_fill.sv =====
// a visible or flushing transfer emits its results from the captured run; each interpolated
// result first waits for the three dividers (57-step divider)
// a buffered occluded frame is only counted and the block stays idle for the next frame;
// otherwise the input stalls until every result of the run has been sent, plus any output stall
// reset: synchronous, active high; clears held frame, pending count and handshake state
module linear_gap_fill #(
   parameter int MAX_GAP = lgf_pkg::MaxGapDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic               req_hidden,
   input  logic               req_final_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_out_x,
   output logic signed [23:0] rsp_out_y,
   output logic signed [23:0] rsp_out_z,
   output logic               rsp_out_hidden,
   output logic [1:0]         rsp_fill_kind,
   output logic               rsp_run_end,
   output logic               rsp_sequence_end
);
   import lgf_pkg::*;

   cmd_type    cmd;
   status_type status;

   lgf_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .status, .cmd
   );

   lgf_datapath #(.MAX_GAP(MAX_GAP)) u_datapath (
      .clock, .reset, .cmd, .status,
      .req_pos_x, .req_pos_y, .req_pos_z, .req_hidden, .req_final_frame,
      .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_out_hidden, .rsp_fill_kind,
      .rsp_run_end, .rsp_sequence_end
   );

endmodule
